// ----- design/tdag_pkg.sv -----
// Package for the time displacement address generator.
// Holds field widths, register and mode codes, and the derived configuration bundle.
// No dependencies.
package tdag_pkg;

  // Item field widths
  localparam int ROW_W   = 11;
  localparam int COL_W   = 11;
  localparam int MAP_W   = 16;
  localparam int FRAME_W = 8;

  // Configuration register widths
  localparam int MODE_W  = 2;
  localparam int OFF_W   = 8;
  localparam int SIZE_W  = 12;
  localparam int DEPTH_W = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Slice height and reciprocal widths
  localparam int SLICE_W   = 12;
  localparam int SHIFT_S   = 24;            // band = (x * recip_s) >> SHIFT_S
  localparam int RECIP_S_W = SHIFT_S + 1;
  localparam int SHIFT_D   = 26;            // q = (x * recip_d) >> SHIFT_D
  localparam int RECIP_D_W = SHIFT_D + 1;
  localparam int XMOD_W    = 17;            // map_value + sync_offset

  // Serial divider widths
  localparam int DIV_NUM_W = 27;
  localparam int DIV_DEN_W = 12;
  localparam int DIV_CNT_W = 5;

  // Stream payload widths
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SQUISH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 3'd5;

  // Mode codes (code 3 behaves as row bands)
  localparam logic [MODE_W-1:0] MODE_ROW = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MAP = 2'd2;

  // Configuration and precomputed terms seen by the datapath
  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic                 squish;
    logic [OFF_W-1:0]     sync_offset;
    logic [DEPTH_W-1:0]   depth;       // limited depth, 1..MAX_DEPTH
    logic [DEPTH_W-1:0]   off_mod;     // sync_offset mod depth
    logic [SIZE_W-1:0]    h_max;       // limited height - 1
    logic [SLICE_W-1:0]   slice_h;     // ceil(height / depth)
    logic [RECIP_S_W-1:0] recip_h;     // floor(2^24 / slice_h) + 1
    logic [RECIP_S_W-1:0] recip_w;     // floor(2^24 / slice_w) + 1
    logic [RECIP_D_W-1:0] recip_d;     // floor(2^26 / depth) + 1
  } tdag_derived_t;

endpackage

// ----- design/tdag_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Used by the configuration block to precompute slice heights and reciprocals.
// Depends on tdag_pkg.
module tdag_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tdag_pkg::DIV_NUM_W-1:0] dividend,
  input  logic [tdag_pkg::DIV_DEN_W-1:0] divisor,
  output logic                           done,
  output logic [tdag_pkg::DIV_NUM_W-1:0] quotient,
  output logic [tdag_pkg::DIV_DEN_W-1:0] remainder
);
  import tdag_pkg::*;

  logic                 running;
  logic [DIV_CNT_W-1:0] count;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  // Shift in the next dividend bit and try the divisor
  always_comb begin
    trial = {rem, quo[DIV_NUM_W-1]};
    fits  = (trial >= {1'b0, den});
  end

  // Control: count the steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        count <= count + 1'b1;
        if (count == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then one step per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      den <= divisor;
      quo <= dividend;
      rem <= '0;
    end else if (running) begin
      rem <= fits ? DIV_DEN_W'(trial - {1'b0, den}) : trial[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ----- design/tdag_cfg.sv -----
// Configuration registers and the sequencer that precomputes derived terms.
// Runs six divisions on the shared serial divider after reset and each write.
// Depends on tdag_pkg and tdag_div.
module tdag_cfg #(
  parameter int MAX_DEPTH  = 256,
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tdag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tdag_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            busy,
  output tdag_pkg::tdag_derived_t         derived
);
  import tdag_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_LAUNCH, ST_WAIT} seq_state_t;
  localparam logic [2:0] STEP_LAST = 3'd5;

  logic [MODE_W-1:0]  mode;
  logic [OFF_W-1:0]   sync_offset;
  logic               squish;
  logic [SIZE_W-1:0]  frame_width;
  logic [SIZE_W-1:0]  frame_height;
  logic [DEPTH_W-1:0] frame_depth;

  logic [SIZE_W-1:0]  w_lim;
  logic [SIZE_W-1:0]  h_lim;
  logic [DEPTH_W-1:0] d_lim;

  seq_state_t state;
  logic [2:0] step;

  logic [SLICE_W-1:0]   slice_h;
  logic [SLICE_W-1:0]   slice_w;
  logic [RECIP_S_W-1:0] recip_h;
  logic [RECIP_S_W-1:0] recip_w;
  logic [RECIP_D_W-1:0] recip_d;
  logic [DEPTH_W-1:0]   off_mod;

  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [DIV_DEN_W-1:0] div_rem;
  logic                 cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_ROW;
      sync_offset  <= '0;
      squish       <= 1'b0;
      frame_width  <= SIZE_W'(640);
      frame_height <= SIZE_W'(480);
      frame_depth  <= DEPTH_W'(16);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE:   mode         <= cfg_data[MODE_W-1:0];
        REG_SYNC:   sync_offset  <= cfg_data[OFF_W-1:0];
        REG_SQUISH: squish       <= cfg_data[0];
        REG_WIDTH:  frame_width  <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT: frame_height <= cfg_data[SIZE_W-1:0];
        REG_DEPTH:  frame_depth  <= cfg_data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Limit sizes: zero reads as one, oversize saturates
  always_comb begin
    if (frame_width == '0)                 w_lim = SIZE_W'(1);
    else if (32'(frame_width) > MAX_WIDTH) w_lim = SIZE_W'(MAX_WIDTH);
    else                                   w_lim = frame_width;
    if (frame_height == '0)                  h_lim = SIZE_W'(1);
    else if (32'(frame_height) > MAX_HEIGHT) h_lim = SIZE_W'(MAX_HEIGHT);
    else                                     h_lim = frame_height;
    if (frame_depth == '0)                 d_lim = DEPTH_W'(1);
    else if (32'(frame_depth) > MAX_DEPTH) d_lim = DEPTH_W'(MAX_DEPTH);
    else                                   d_lim = frame_depth;
  end

  // Operands of each division step
  always_comb begin
    case (step)
      3'd0: begin
        div_num = DIV_NUM_W'(h_lim) + DIV_NUM_W'(d_lim) - DIV_NUM_W'(1);
        div_den = DIV_DEN_W'(d_lim);
      end
      3'd1: begin
        div_num = DIV_NUM_W'(w_lim) + DIV_NUM_W'(d_lim) - DIV_NUM_W'(1);
        div_den = DIV_DEN_W'(d_lim);
      end
      3'd2: begin
        div_num = DIV_NUM_W'(1) << SHIFT_D;
        div_den = DIV_DEN_W'(d_lim);
      end
      3'd3: begin
        div_num = DIV_NUM_W'(sync_offset);
        div_den = DIV_DEN_W'(d_lim);
      end
      3'd4: begin
        div_num = DIV_NUM_W'(1) << SHIFT_S;
        div_den = slice_h;
      end
      default: begin
        div_num = DIV_NUM_W'(1) << SHIFT_S;
        div_den = slice_w;
      end
    endcase
  end

  assign div_start = (state == ST_LAUNCH);

  tdag_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_num),
    .divisor   (div_den),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Sequencer: restart on every write, step through the divisions
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LAUNCH;
      step  <= '0;
    end else if (cfg_write) begin
      state <= ST_LAUNCH;
      step  <= '0;
    end else begin
      case (state)
        ST_LAUNCH: state <= ST_WAIT;
        ST_WAIT: begin
          if (div_done) begin
            if (step == STEP_LAST) begin
              state <= ST_IDLE;
            end else begin
              step  <= step + 3'd1;
              state <= ST_LAUNCH;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Capture each division result
  always_ff @(posedge clk) begin
    if (state == ST_WAIT && div_done && !cfg_write) begin
      case (step)
        3'd0:    slice_h <= div_quo[SLICE_W-1:0];
        3'd1:    slice_w <= div_quo[SLICE_W-1:0];
        3'd2:    recip_d <= div_quo[RECIP_D_W-1:0] + RECIP_D_W'(1);
        3'd3:    off_mod <= div_rem[DEPTH_W-1:0];
        3'd4:    recip_h <= div_quo[RECIP_S_W-1:0] + RECIP_S_W'(1);
        default: recip_w <= div_quo[RECIP_S_W-1:0] + RECIP_S_W'(1);
      endcase
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    derived.mode        = mode;
    derived.squish      = squish;
    derived.sync_offset = sync_offset;
    derived.depth       = d_lim;
    derived.off_mod     = off_mod;
    derived.h_max       = h_lim - SIZE_W'(1);
    derived.slice_h     = slice_h;
    derived.recip_h     = recip_h;
    derived.recip_w     = recip_w;
    derived.recip_d     = recip_d;
  end

endmodule

// ----- design/tdag_pipe.sv -----
// Five-stage address datapath with per-stage valid bits and bubble collapsing.
// Band by reciprocal multiply, modulo depth by reciprocal multiply and correction.
// Depends on tdag_pkg.
module tdag_pipe (
  input  logic                          clk,
  input  logic                          rst,
  input  tdag_pkg::tdag_derived_t       derived,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tdag_pkg::ROW_W-1:0]    in_row,
  input  logic [tdag_pkg::COL_W-1:0]    in_col,
  input  logic [tdag_pkg::MAP_W-1:0]    in_map,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tdag_pkg::FRAME_W-1:0]  out_frame,
  output logic [tdag_pkg::ROW_W-1:0]    out_row,
  output logic [tdag_pkg::COL_W-1:0]    out_col
);
  import tdag_pkg::*;

  localparam int PB_W = ROW_W + RECIP_S_W;   // band product
  localparam int PS_W = ROW_W + SLICE_W;     // squish row product
  localparam int PM_W = XMOD_W + RECIP_D_W;  // modulo product
  localparam int QD_W = XMOD_W + DEPTH_W;

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  // Stage 1 registers
  logic [ROW_W-1:0] s1_row;
  logic [COL_W-1:0] s1_col;
  logic [MAP_W-1:0] s1_map;
  logic [PB_W-1:0]  s1_prod_band;
  logic [PS_W-1:0]  s1_prod_sq;
  // Stage 2 registers
  logic [XMOD_W-1:0] s2_x;
  logic [ROW_W-1:0]  s2_srow;
  logic [COL_W-1:0]  s2_col;
  // Stage 3 registers
  logic [XMOD_W-1:0] s3_x;
  logic [PM_W-1:0]   s3_prod;
  logic [ROW_W-1:0]  s3_srow;
  logic [COL_W-1:0]  s3_col;
  // Stage 4 registers
  logic [DEPTH_W-1:0] s4_r;
  logic [ROW_W-1:0]   s4_srow;
  logic [COL_W-1:0]   s4_col;
  // Stage 5 (output) registers
  logic [FRAME_W-1:0] s5_frame;
  logic [ROW_W-1:0]   s5_srow;
  logic [COL_W-1:0]   s5_col;

  logic [ROW_W-1:0]     x_div;
  logic [RECIP_S_W-1:0] recip_s;
  logic [ROW_W-1:0]     q_band;
  logic [XMOD_W-1:0]    x_next;
  logic [ROW_W-1:0]     srow_next;
  logic [XMOD_W-1:0]    qd;
  logic [QD_W-1:0]      qd_times;
  logic [XMOD_W-1:0]    r_full;
  logic [DEPTH_W-1:0]   t_base;
  logic [DEPTH_W:0]     t_sum;
  logic [DEPTH_W-1:0]   t_wrap;
  logic                 use_map;

  // Stage enables: a stage loads when it is empty or the next one moves
  always_comb begin
    en5 = !v5 || out_ready;
    en4 = !v4 || en5;
    en3 = !v3 || en4;
    en2 = !v2 || en3;
    en1 = !v1 || en2;
  end

  assign in_ready = en1;
  assign use_map  = !derived.squish && (derived.mode == MODE_MAP);

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Stage 1: pick the band coordinate, multiply by the slice reciprocal
  always_comb begin
    if (derived.mode == MODE_COL) begin
      x_div   = in_col;
      recip_s = derived.recip_w;
    end else begin
      x_div   = in_row;
      recip_s = derived.recip_h;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_row       <= in_row;
      s1_col       <= in_col;
      s1_map       <= in_map;
      s1_prod_band <= PB_W'(x_div) * PB_W'(recip_s);
      s1_prod_sq   <= PS_W'(in_row) * PS_W'(derived.slice_h);
    end
  end

  // Stage 2: select the value to reduce mod depth, clamp the squish row
  always_comb begin
    q_band = s1_prod_band[SHIFT_S +: ROW_W];
    if (derived.squish) begin
      x_next = XMOD_W'(s1_row);
    end else if (derived.mode == MODE_MAP) begin
      x_next = XMOD_W'(s1_map) + XMOD_W'(derived.sync_offset);
    end else begin
      x_next = XMOD_W'(q_band);
    end
    if (!derived.squish) begin
      srow_next = s1_row;
    end else if (s1_prod_sq > PS_W'(derived.h_max)) begin
      srow_next = derived.h_max[ROW_W-1:0];
    end else begin
      srow_next = s1_prod_sq[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_x    <= x_next;
      s2_srow <= srow_next;
      s2_col  <= s1_col;
    end
  end

  // Stage 3: multiply by the depth reciprocal
  always_ff @(posedge clk) begin
    if (en3) begin
      s3_x    <= s2_x;
      s3_prod <= PM_W'(s2_x) * PM_W'(derived.recip_d);
      s3_srow <= s2_srow;
      s3_col  <= s2_col;
    end
  end

  // Stage 4: remainder = x - quotient * depth
  always_comb begin
    qd       = s3_prod[SHIFT_D +: XMOD_W];
    qd_times = QD_W'(qd) * QD_W'(derived.depth);
    r_full   = s3_x - qd_times[XMOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_r    <= r_full[DEPTH_W-1:0];
      s4_srow <= s3_srow;
      s4_col  <= s3_col;
    end
  end

  // Stage 5: mirror the band and add the offset, wrap once; map mode passes the remainder through
  always_comb begin
    t_base = derived.depth - DEPTH_W'(1) - s4_r;
    t_sum  = (DEPTH_W + 1)'(t_base) + (DEPTH_W + 1)'(derived.off_mod);
    if (t_sum >= (DEPTH_W + 1)'(derived.depth)) begin
      t_wrap = DEPTH_W'(t_sum - (DEPTH_W + 1)'(derived.depth));
    end else begin
      t_wrap = t_sum[DEPTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_frame <= use_map ? s4_r[FRAME_W-1:0] : t_wrap[FRAME_W-1:0];
      s5_srow  <= s4_srow;
      s5_col   <= s4_col;
    end
  end

  assign out_valid = v5;
  assign out_frame = s5_frame;
  assign out_row   = s5_srow;
  assign out_col   = s5_col;

endmodule

// ----- design/time_displacement_address_gen.sv -----
// Slit-scan time displacement address generator, top level.
// Maps each output pixel to a source frame, row and column of a frame cube.
// Usage:
//   Slave stream carries one output pixel per transaction (row, column, map value).
//   Master stream returns one transaction per input: source frame, row, column.
//   The config channel writes registers 0..5 (mode, sync_offset, squish, width,
//   height, depth); cfg_ready is always high, indexes 6 and 7 are ignored.
// Timing:
//   An accepted input passes through the stage registers s1 to s5 before m_tvalid
//   rises. The datapath is a five-stage pipeline and takes one pixel per clock
//   while m_tready is high and the config block is not busy.
//   After reset and after every register write, a shared serial divider works out
//   slice heights, reciprocals and the offset modulo in six divisions, and s_tready
//   stays low until they are done. Config writes are taken throughout.
// Stalls:
//   Each stage has its own valid bit; when m_tready is low, empty stages still fill,
//   so up to five transactions are held and none is lost or repeated.
// Depends on tdag_pkg, tdag_cfg, tdag_div and tdag_pipe.
module time_displacement_address_gen #(
  parameter int MAX_DEPTH  = 256,
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata: out_row [10:0], out_col [21:11], map_value [37:22], zero [39:38]
  input  logic [tdag_pkg::S_TDATA_W-1:0]  s_tdata,
  // Result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata: source_frame [7:0], source_row [18:8], source_col [29:19], zero [31:30]
  output logic [tdag_pkg::M_TDATA_W-1:0]  m_tdata,
  // Configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tdag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tdag_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tdag_pkg::*;

  tdag_derived_t      derived;
  logic               cfg_busy;
  logic               pipe_ready;
  logic [FRAME_W-1:0] res_frame;
  logic [ROW_W-1:0]   res_row;
  logic [COL_W-1:0]   res_col;

  tdag_cfg #(
    .MAX_DEPTH  (MAX_DEPTH),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (cfg_busy),
    .derived   (derived)
  );

  // Hold off input while derived terms are being computed
  assign s_tready = pipe_ready & !cfg_busy;

  tdag_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .derived   (derived),
    .in_valid  (s_tvalid & !cfg_busy),
    .in_ready  (pipe_ready),
    .in_row    (s_tdata[ROW_W-1:0]),
    .in_col    (s_tdata[ROW_W +: COL_W]),
    .in_map    (s_tdata[ROW_W + COL_W +: MAP_W]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_frame (res_frame),
    .out_row   (res_row),
    .out_col   (res_col)
  );

  assign m_tdata = {{(M_TDATA_W - FRAME_W - ROW_W - COL_W){1'b0}}, res_col, res_row, res_frame};

endmodule
